/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the validator RTL.
// Needs nothing else; each use names its own clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/ntv_pkg.sv */
// Shared constants, types and the CDATA literal table for the tag validator.
// No dependencies.
package ntv_pkg;

    localparam int STACK_DEPTH_DEF  = 32;
    localparam int MAX_NAME_LEN_DEF = 9;
    localparam int LETTER_W         = 5;
    localparam int CDATA_LEN        = 7;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_Z      = 8'h5A;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_ctl_t;

    typedef struct packed {
        logic empty;
        logic one;
        logic full;
    } stack_stat_t;

    // Characters that follow "<!" in "<![CDATA["
    function automatic logic [7:0] cdata_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h5B;
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h44;
            3'd3:    ch = 8'h41;
            3'd4:    ch = 8'h54;
            3'd5:    ch = 8'h41;
            3'd6:    ch = 8'h5B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/ntv_if.sv */
// Valid/ready channels for document characters and verdicts.
// Needs nothing else.
interface ntv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface ntv_verdict_if;
    logic valid;
    logic ready;
    logic doc_valid;
    logic depth_overflow;

    modport source (output valid, output doc_valid, output depth_overflow, input ready);
    modport sink   (input valid, input doc_valid, input depth_overflow, output ready);
endinterface

/* hw/rtl/ntv_stack.sv */
// Tag-name stack: entry memory, stack pointer and registered top-of-stack read.
// Uses ntv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ntv_stack #(
    parameter int DEPTH   = 32,
    parameter int ENTRY_W = 49
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ntv_pkg::stack_ctl_t  ctl,
    input  logic [ENTRY_W-1:0]   wr_entry,
    output logic [ENTRY_W-1:0]   top_entry,
    output ntv_pkg::stack_stat_t stat
);
    import ntv_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SP_W   = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [SP_W-1:0]    sp_next;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    assign wr_addr = sp_reg[ADDR_W-1:0];
    assign rd_addr = ADDR_W'(sp_reg - SP_W'(1));

    always_comb
    begin
        priority if (ctl.clear)
        begin
            sp_next = '0;
        end
        else if (ctl.push)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
        else if (ctl.pop)
        begin
            sp_next = sp_reg - SP_W'(1);
        end
        else
        begin
            sp_next = sp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    // A close tag is at least four characters after any push or pop,
    // so the registered top read is always current when compared.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_reg <= mem[rd_addr];
    end

    assign top_entry  = rd_reg;
    assign stat.empty = (sp_reg == '0);
    assign stat.one   = (sp_reg == SP_W'(1));
    assign stat.full  = (sp_reg == SP_W'(DEPTH));

    `ASSERT_NEVER(a_push_full, clk, rst_n, ctl.push && stat.full)
    `ASSERT_NEVER(a_pop_empty, clk, rst_n, ctl.pop && stat.empty)
    `ASSERT_CLK(a_push_grows, clk, rst_n,
        (ctl.push && !ctl.clear) |=> (sp_reg == $past(sp_reg) + SP_W'(1)))

endmodule

/* hw/rtl/ntv_parser.sv */
// Character-level parser: mode machine, CDATA matcher, name buffer, verdict.
// Uses ntv_pkg and assert_macros.svh; drives ntv_stack through a control struct.
`include "assert_macros.svh"

module ntv_parser #(
    parameter int MAX_NAME_LEN = 9,
    parameter int NAME_W       = 45,
    parameter int LEN_W        = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [7:0]                ch,
    input  logic                      last,
    input  logic [NAME_W+LEN_W-1:0]   top_entry,
    input  ntv_pkg::stack_stat_t      stat,
    output ntv_pkg::stack_ctl_t       ctl,
    output logic [NAME_W+LEN_W-1:0]   entry,
    output logic                      doc_ok,
    output logic                      doc_ovf
);
    import ntv_pkg::*;

    localparam logic [3:0] MODE_START      = 4'd0;
    localparam logic [3:0] MODE_LT_FIRST   = 4'd1;
    localparam logic [3:0] MODE_CONTENT    = 4'd2;
    localparam logic [3:0] MODE_LT         = 4'd3;
    localparam logic [3:0] MODE_OPEN_NAME  = 4'd4;
    localparam logic [3:0] MODE_CLOSE_NAME = 4'd5;
    localparam logic [3:0] MODE_CDATA_OPEN = 4'd6;
    localparam logic [3:0] MODE_CDATA_BODY = 4'd7;
    localparam logic [3:0] MODE_DONE       = 4'd8;

    logic [3:0]        mode_reg, mode_next, mode_step;
    logic [2:0]        cnt_reg, cnt_next, cnt_step;
    logic [NAME_W-1:0] name_reg, name_next, name_step;
    logic [LEN_W-1:0]  len_reg, len_next, len_step;
    logic              err_reg, err_next, err_step;
    logic              ovf_reg, ovf_next, ovf_step;
    logic              is_upper;
    logic [7:0]        ch_off;
    logic [NAME_W-1:0] letter;
    logic [2:0]        cnt_inc;

    assign is_upper = (ch >= CH_A) && (ch <= CH_Z);
    assign ch_off   = ch - CH_A;
    assign letter   = NAME_W'(ch_off[LETTER_W-1:0]);
    assign cnt_inc  = cnt_reg + 3'd1;
    assign entry    = {len_reg, name_reg};

    always_comb
    begin
        mode_step = mode_reg;
        cnt_step  = cnt_reg;
        name_step = name_reg;
        len_step  = len_reg;
        err_step  = err_reg;
        ovf_step  = ovf_reg;
        ctl       = '0;

        if (fire && !err_reg)
        begin
            unique case (mode_reg)
                MODE_START:
                begin
                    if (ch == CH_LT) mode_step = MODE_LT_FIRST;
                    else             err_step  = 1'b1;
                end
                MODE_LT_FIRST:
                begin
                    if (is_upper)
                    begin
                        name_step = letter;
                        len_step  = LEN_W'(1);
                        mode_step = MODE_OPEN_NAME;
                    end
                    else
                    begin
                        err_step = 1'b1;
                    end
                end
                MODE_CONTENT:
                begin
                    if (ch == CH_LT) mode_step = MODE_LT;
                end
                MODE_LT:
                begin
                    priority if (ch == CH_SLASH)
                    begin
                        name_step = '0;
                        len_step  = '0;
                        mode_step = MODE_CLOSE_NAME;
                    end
                    else if (ch == CH_BANG)
                    begin
                        cnt_step  = '0;
                        mode_step = MODE_CDATA_OPEN;
                    end
                    else if (is_upper)
                    begin
                        name_step = letter;
                        len_step  = LEN_W'(1);
                        mode_step = MODE_OPEN_NAME;
                    end
                    else
                    begin
                        err_step = 1'b1;
                    end
                end
                MODE_OPEN_NAME, MODE_CLOSE_NAME:
                begin
                    priority if (is_upper)
                    begin
                        if (len_reg == '0)
                        begin
                            name_step = letter;
                            len_step  = LEN_W'(1);
                        end
                        else if (len_reg >= LEN_W'(MAX_NAME_LEN))
                        begin
                            err_step = 1'b1;
                        end
                        else
                        begin
                            name_step = (name_reg << LETTER_W) | letter;
                            len_step  = len_reg + LEN_W'(1);
                        end
                    end
                    else if (ch == CH_GT && mode_reg == MODE_OPEN_NAME)
                    begin
                        if (stat.full)
                        begin
                            ovf_step = 1'b1;
                            err_step = 1'b1;
                        end
                        else
                        begin
                            ctl.push  = 1'b1;
                            mode_step = MODE_CONTENT;
                        end
                    end
                    else if (ch == CH_GT)
                    begin
                        if (len_reg == '0 || stat.empty || top_entry != entry)
                        begin
                            err_step = 1'b1;
                        end
                        else
                        begin
                            ctl.pop   = 1'b1;
                            mode_step = stat.one ? MODE_DONE : MODE_CONTENT;
                        end
                    end
                    else
                    begin
                        err_step = 1'b1;
                    end
                end
                MODE_CDATA_OPEN:
                begin
                    if (ch == cdata_char(cnt_reg))
                    begin
                        if (cnt_inc == 3'(CDATA_LEN))
                        begin
                            cnt_step  = '0;
                            mode_step = MODE_CDATA_BODY;
                        end
                        else
                        begin
                            cnt_step = cnt_inc;
                        end
                    end
                    else
                    begin
                        err_step = 1'b1;
                    end
                end
                MODE_CDATA_BODY:
                begin
                    priority if (ch == CH_RBRACK)
                    begin
                        if (cnt_reg < 3'd2) cnt_step = cnt_inc;
                    end
                    else if (ch == CH_GT && cnt_reg >= 3'd2)
                    begin
                        cnt_step  = '0;
                        mode_step = MODE_CONTENT;
                    end
                    else
                    begin
                        cnt_step = '0;
                    end
                end
                default:
                begin
                    err_step = 1'b1;
                end
            endcase
        end

        doc_ok  = !err_step && (mode_step == MODE_DONE);
        doc_ovf = ovf_step;

        // Clear for the next document after the final character
        ctl.clear = fire && last;
        if (ctl.clear)
        begin
            mode_next = MODE_START;
            cnt_next  = '0;
            name_next = '0;
            len_next  = '0;
            err_next  = 1'b0;
            ovf_next  = 1'b0;
        end
        else
        begin
            mode_next = mode_step;
            cnt_next  = cnt_step;
            name_next = name_step;
            len_next  = len_step;
            err_next  = err_step;
            ovf_next  = ovf_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_START;
            cnt_reg  <= '0;
            name_reg <= '0;
            len_reg  <= '0;
            err_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            name_reg <= name_next;
            len_reg  <= len_next;
            err_reg  <= err_next;
            ovf_reg  <= ovf_next;
        end
    end

    `ASSERT_CLK(a_ovf_err, clk, rst_n, ovf_reg |-> err_reg)
    `ASSERT_CLK(a_done_empty, clk, rst_n, (mode_reg == MODE_DONE) |-> stat.empty)
    `ASSERT_CLK(a_body_cnt, clk, rst_n, (mode_reg == MODE_CDATA_BODY) |-> (cnt_reg <= 3'd2))

endmodule

/* hw/rtl/nested_tag_validator.sv */
// Top level of the nested tag validator: input register, parser, tag stack, verdict register.
// Uses ntv_pkg, ntv_if, ntv_parser and ntv_stack.
//
//  channel   dir  payload                      moves
//  chars     in   byte_in[7:0], last_byte      one document character per item
//  verdict   out  doc_valid, depth_overflow    one item per document, on its last character
//
// One character per cycle unless a held verdict stalls; each item waits in the input register
// and a verdict appears in the output register the cycle after the last character is parsed.
// The per-character path is the mode update plus one compare against the stack top.
// rst_n clears the parser and stack pointer; stack memory needs no clearing pass.
// A held verdict stalls only a following last character; other characters keep flowing.
module nested_tag_validator #(
    parameter int STACK_DEPTH  = ntv_pkg::STACK_DEPTH_DEF,
    parameter int MAX_NAME_LEN = ntv_pkg::MAX_NAME_LEN_DEF
) (
    input logic         clk,
    input logic         rst_n,
    ntv_char_if.sink    chars,
    ntv_verdict_if.source verdict
);
    import ntv_pkg::*;

    localparam int NAME_W  = LETTER_W * MAX_NAME_LEN;
    localparam int LEN_W   = $clog2(MAX_NAME_LEN + 1);
    localparam int ENTRY_W = NAME_W + LEN_W;

    logic               hold_valid_reg;
    logic [7:0]         hold_byte_reg;
    logic               hold_last_reg;
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic               out_ovf_reg;
    logic               out_free;
    logic               advance;
    logic               doc_ok;
    logic               doc_ovf;
    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] top_entry;
    stack_ctl_t         ctl;
    stack_stat_t        stat;

    assign out_free    = !out_valid_reg || verdict.ready;
    assign advance     = hold_valid_reg && (!hold_last_reg || out_free);
    assign chars.ready = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (chars.ready)
            begin
                hold_valid_reg <= chars.valid;
            end
            if (advance && hold_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (verdict.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            hold_byte_reg <= chars.byte_in;
            hold_last_reg <= chars.last_byte;
        end
        if (advance && hold_last_reg)
        begin
            out_ok_reg  <= doc_ok;
            out_ovf_reg <= doc_ovf;
        end
    end

    ntv_parser #(
        .MAX_NAME_LEN (MAX_NAME_LEN),
        .NAME_W       (NAME_W),
        .LEN_W        (LEN_W)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .ch        (hold_byte_reg),
        .last      (hold_last_reg),
        .top_entry (top_entry),
        .stat      (stat),
        .ctl       (ctl),
        .entry     (entry),
        .doc_ok    (doc_ok),
        .doc_ovf   (doc_ovf)
    );

    ntv_stack #(
        .DEPTH   (STACK_DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .wr_entry  (entry),
        .top_entry (top_entry),
        .stat      (stat)
    );

    assign verdict.valid          = out_valid_reg;
    assign verdict.doc_valid      = out_ok_reg;
    assign verdict.depth_overflow = out_ovf_reg;

endmodule
